// File: hw/rtl/cfacc_pkg.sv
`default_nettype none
package cfacc_pkg;

	localparam logic [2:0] MODE_ADD   = 3'd0;
	localparam logic [2:0] MODE_SUB   = 3'd1;
	localparam logic [2:0] MODE_CMP   = 3'd2;
	localparam logic [2:0] MODE_ITOR  = 3'd3;
	localparam logic [2:0] MODE_TRUNC = 3'd4;
	localparam logic [2:0] MODE_FLOOR = 3'd5;
	localparam logic [2:0] MODE_SCALE = 3'd6;

	localparam logic [1:0] CMP_LESS    = 2'd0;
	localparam logic [1:0] CMP_EQUAL   = 2'd1;
	localparam logic [1:0] CMP_GREATER = 2'd2;

	localparam logic [15:0] MAN_INF = 16'hFFFF;

	typedef struct packed {
		logic [2:0]        mode;
		logic              a_sign;
		logic signed [7:0] a_exp;
		logic [15:0]       a_man;
		logic              b_sign;
		logic signed [7:0] b_exp;
		logic [15:0]       b_man;
		logic signed [15:0] int_value;
		logic signed [7:0] scale_amount;
	} req_t;

	typedef struct packed {
		logic              r_sign;
		logic signed [7:0] r_exp;
		logic [15:0]       r_man;
		logic signed [15:0] int_result;
		logic [1:0]        compare_result;
	} rsp_t;

	// leading zero count of a 16-bit word, 16 when zero
	function automatic logic [4:0] lzc16(input logic [15:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd16;
		found = 1'b0;
		for (int i = 15; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 5'(15 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cfacc_core.sv
`default_nettype none
module cfacc_core #(
	parameter int MAX_EXP = 127,
	parameter int MIN_EXP = -128
) (
	input  wire cfacc_pkg::req_t req,
	output cfacc_pkg::rsp_t      rsp
);

	localparam logic signed [9:0] MAX_E = 10'(MAX_EXP);
	localparam logic signed [9:0] MIN_E = 10'(MIN_EXP);
	localparam logic signed [9:0] FLUSH_E = -10'sd128;

	logic signed [9:0] a_e, b_e, big_e, sml_e, sh, e_inc, e_norm, sc_e, tsh, tn;
	logic              b_sg, a_nz, b_nz, a_big, big_s, sml_s;
	logic [15:0]       big_m, sml_m, sm, dmag, iabs, tv, fv, imask, nmask;
	logic [16:0]       sum;
	logic signed [17:0] diff;
	logic [4:0]        lz, ilz;
	logic              rem;
	logic              r_s;
	logic signed [7:0] r_e;
	logic [15:0]       r_m;
	logic [15:0]       ires;
	logic [1:0]        cres;

	always_comb begin
		a_e = 10'(req.a_exp);
		b_e = 10'(req.b_exp);
		b_sg = req.b_sign ^ (req.mode == cfacc_pkg::MODE_SUB);
		a_nz = req.a_man[15];
		b_nz = req.b_man[15];
		a_big = a_e >= b_e;
		big_e = a_big ? a_e : b_e;
		sml_e = a_big ? b_e : a_e;
		big_m = a_big ? req.a_man : req.b_man;
		sml_m = a_big ? req.b_man : req.a_man;
		big_s = a_big ? req.a_sign : b_sg;
		sml_s = a_big ? b_sg : req.a_sign;
		sh = big_e - sml_e;
		sm = (sh >= 10'sd16) ? 16'd0 : (sml_m >> sh[3:0]);
		sum = {1'b0, big_m} + {1'b0, sm};
		e_inc = big_e + 10'sd1;
		diff = signed'({2'b00, big_m}) - signed'({2'b00, sm});
		dmag = diff[17] ? 16'(-diff) : diff[15:0];
		lz = cfacc_pkg::lzc16(dmag);
		e_norm = big_e - 10'(lz);

		iabs = req.int_value[15] ? 16'(-req.int_value) : req.int_value;
		ilz = cfacc_pkg::lzc16(iabs);

		sc_e = a_e + 10'(req.scale_amount);

		tsh = a_e - 10'sd15;
		tn = -tsh;
		if (tsh == 10'sd0) begin
			tv = req.a_man & 16'h7FFF;
		end else if (tsh > 10'sd0) begin
			tv = (tsh >= 10'sd16) ? 16'd0 : (req.a_man << tsh[3:0]);
		end else begin
			tv = (tn >= 10'sd16) ? 16'd0 : ((req.a_man >> tn[3:0]) & 16'h7FFF);
		end
		nmask = (16'h1 << tn[3:0]) - 16'h1;
		rem = (tn >= 10'sd16) ? 1'b1 : ((req.a_man & nmask) != 16'd0);
		imask = req.a_sign ? 16'(-tv) : tv;
		if (tsh >= 10'sd0) begin
			fv = imask;
		end else begin
			fv = req.a_sign ? 16'(16'd0 - tv - 16'(rem)) : tv;
		end

		r_s = 1'b0;
		r_e = '0;
		r_m = '0;
		ires = '0;
		cres = cfacc_pkg::CMP_LESS;
		unique case (req.mode)
			cfacc_pkg::MODE_ADD, cfacc_pkg::MODE_SUB: begin
				if (!b_nz) begin
					r_s = req.a_sign; r_e = req.a_exp; r_m = req.a_man;
				end else if (!a_nz) begin
					r_s = b_sg; r_e = req.b_exp; r_m = req.b_man;
				end else if (sh >= 10'sd16) begin
					r_s = big_s; r_e = big_e[7:0]; r_m = big_m;
				end else if (big_s == sml_s) begin
					if (sum[16]) begin
						r_s = big_s;
						if (e_inc > MAX_E) begin
							r_e = MAX_E[7:0]; r_m = cfacc_pkg::MAN_INF;
						end else begin
							r_e = e_inc[7:0]; r_m = sum[16:1];
						end
					end else begin
						r_s = big_s; r_e = big_e[7:0]; r_m = sum[15:0];
					end
				end else if (dmag != 16'd0 && e_norm >= FLUSH_E) begin
					r_s = big_s ^ diff[17];
					r_e = e_norm[7:0];
					r_m = dmag << lz[3:0];
				end
			end
			cfacc_pkg::MODE_CMP: begin
				if (!a_nz && !b_nz) cres = cfacc_pkg::CMP_EQUAL;
				else if (!a_nz) cres = req.b_sign ? cfacc_pkg::CMP_GREATER : cfacc_pkg::CMP_LESS;
				else if (!b_nz) cres = req.a_sign ? cfacc_pkg::CMP_LESS : cfacc_pkg::CMP_GREATER;
				else if (req.a_sign != req.b_sign)
					cres = req.a_sign ? cfacc_pkg::CMP_LESS : cfacc_pkg::CMP_GREATER;
				else if (a_e == b_e && req.a_man == req.b_man) cres = cfacc_pkg::CMP_EQUAL;
				else if ((a_e > b_e || (a_e == b_e && req.a_man > req.b_man)) ^ req.a_sign)
					cres = cfacc_pkg::CMP_GREATER;
				else cres = cfacc_pkg::CMP_LESS;
			end
			cfacc_pkg::MODE_ITOR: begin
				r_s = req.int_value[15];
				r_e = 8'(5'd15 - ilz);
				r_m = iabs << ilz[3:0];
			end
			cfacc_pkg::MODE_TRUNC: ires = a_nz ? imask : 16'd0;
			cfacc_pkg::MODE_FLOOR: ires = a_nz ? fv : 16'd0;
			cfacc_pkg::MODE_SCALE: begin
				if (a_nz && sc_e > MAX_E) begin
					r_s = req.a_sign; r_e = MAX_E[7:0]; r_m = cfacc_pkg::MAN_INF;
				end else if (a_nz && sc_e >= MIN_E) begin
					r_s = req.a_sign; r_e = sc_e[7:0]; r_m = req.a_man;
				end
			end
			default: ;
		endcase

		rsp.r_sign = r_m[15] ? r_s : 1'b0;
		rsp.r_exp = r_m[15] ? r_e : 8'sd0;
		rsp.r_man = r_m[15] ? r_m : 16'd0;
		rsp.int_result = ires;
		rsp.compare_result = cres;
	end

endmodule
`default_nettype wire

// File: hw/rtl/custom_float_add_compare_convert_alu.sv
// Path: a request taken with start is held in the input register, the core
// computes combinationally, and the result register shows it with done high.
// Throughput: one request per cycle; busy stays low, one input register and
// one result register around a single combinational pass.
// Reset: arst_n clears the valid flags; no result strobe follows reset.
// The receiver cannot stall: done lasts exactly one cycle per request.
`default_nettype none
module custom_float_add_compare_convert_alu #(
	parameter int MAX_EXP = 127,
	parameter int MIN_EXP = -128
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire cfacc_pkg::req_t  req,
	output logic                  done,
	output cfacc_pkg::rsp_t       rsp
);

	cfacc_pkg::req_t req_s1;
	logic            vld_s1;
	cfacc_pkg::rsp_t rsp_c;
	cfacc_pkg::rsp_t rsp_q;
	logic            done_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) req_s1 <= req;
		if (vld_s1) rsp_q <= rsp_c;
	end

	cfacc_core #(
		.MAX_EXP(MAX_EXP),
		.MIN_EXP(MIN_EXP)
	) u_core (
		.req(req_s1),
		.rsp(rsp_c)
	);

	assign done = done_q;
	assign rsp = rsp_q;

	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2)) else $error("result without request");
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done) else $error("request lost");
	a_zero_form: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.r_man[15] |-> rsp.r_exp == 8'sd0 && rsp.r_sign == 1'b0)
		else $error("zero not canonical");
	a_cmp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.compare_result != cfacc_pkg::CMP_LESS |->
		rsp.int_result == 16'sd0 && rsp.r_man == 16'd0 &&
		rsp.compare_result != 2'd3) else $error("compare result mixed");

endmodule
`default_nettype wire
